// ===== sv/q1es_pkg.sv =====
// ----------------------------------------------------------------------------
// q1es_pkg: shared types and constants for the Q1 element stiffness block
// Widths, the pipeline tag and the saturating accumulate helper.
// ----------------------------------------------------------------------------
package q1es_pkg;

   localparam int NUM_BASIS   = 4;
   localparam int NUM_ENTRIES = NUM_BASIS * NUM_BASIS;
   localparam int BASIS_W     = $clog2(NUM_BASIS);
   localparam int ENTRY_W     = $clog2(NUM_ENTRIES);

   localparam int GRAD_W  = 16;
   localparam int WGT_W   = 16;
   localparam int PAIR_W  = 2 * GRAD_W;        // one gradient product
   localparam int ABS_W   = 2 * GRAD_W;        // |dx*dx + dy*dy| <= 2^31
   localparam int SCALE_W = 2 * WGT_W;         // weight * |det|
   localparam int PROD_W  = ABS_W + SCALE_W;
   localparam int RND_SH  = 34;                // 50 -> 16 fraction bits
   localparam int MAG_W   = 29;                // rounded magnitude < 2^28 + 1
   localparam int TERM_W  = MAG_W + 1;
   localparam int ACC_W   = 40;

   typedef logic signed [GRAD_W-1:0] grad_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // travels alongside each term through the pipeline
   typedef struct packed {
      logic valid;
      logic last;    // final entry of the current point
   } tag_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   function automatic acc_type sat_add(acc_type acc, term_type term);
      logic signed [ACC_W:0] sum;
      sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(term);
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sat_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_add = sum[ACC_W-1:0];
      end
   endfunction

endpackage

// ===== sv/q1es_if.sv =====
// ----------------------------------------------------------------------------
// q1es_if: request and response channels
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface q1es_req_if;
   import q1es_pkg::*;

   logic                valid;
   logic                ready;
   logic [WGT_W-1:0]    point_weight;
   logic signed [15:0]  jacobian_det;
   logic signed [15:0]  grad_x_0;
   logic signed [15:0]  grad_x_1;
   logic signed [15:0]  grad_x_2;
   logic signed [15:0]  grad_x_3;
   logic signed [15:0]  grad_y_0;
   logic signed [15:0]  grad_y_1;
   logic signed [15:0]  grad_y_2;
   logic signed [15:0]  grad_y_3;
   logic                last_point;

   modport source (
      output valid, point_weight, jacobian_det,
             grad_x_0, grad_x_1, grad_x_2, grad_x_3,
             grad_y_0, grad_y_1, grad_y_2, grad_y_3, last_point,
      input  ready
   );

   modport sink (
      input  valid, point_weight, jacobian_det,
             grad_x_0, grad_x_1, grad_x_2, grad_x_3,
             grad_y_0, grad_y_1, grad_y_2, grad_y_3, last_point,
      output ready
   );
endinterface

interface q1es_rsp_if;
   import q1es_pkg::*;

   logic                valid;
   logic                ready;
   logic signed [39:0]  entry_value;
   logic [1:0]          row_index;
   logic [1:0]          col_index;
   logic                last_entry;

   modport source (
      output valid, entry_value, row_index, col_index, last_entry,
      input  ready
   );

   modport sink (
      input  valid, entry_value, row_index, col_index, last_entry,
      output ready
   );
endinterface

// ===== sv/q1_element_stiffness_top.sv =====
// ----------------------------------------------------------------------------
// q1_element_stiffness_top: 4x4 stiffness matrix of a bilinear quad element
// Sequence per quadrature point: accept, scale multiply, 16 term issues
//   through the shared term pipeline, then a drain of that pipeline.
// A new point is taken only when idle; a last point then emits its 16 entries.
// Reset: synchronous, active high; clears sequencer and all accumulators.
// ----------------------------------------------------------------------------
module q1_element_stiffness_top (
   input  logic   clock,
   input  logic   reset,
   q1es_req_if.sink   req,
   q1es_rsp_if.source rsp
);
   import q1es_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [ENTRY_W-1:0]  k_ff, k_in;        // entry being issued
   logic [ENTRY_W-1:0]  e_ff, e_in;        // entry being emitted
   logic                last_ff;

   // captured request
   logic [WGT_W-1:0]    w_ff;
   logic [WGT_W-1:0]    adet_ff;
   logic [SCALE_W-1:0]  scale_ff;
   grad_type            rx_ff [NUM_BASIS];   // row copies, rotate once per row
   grad_type            ry_ff [NUM_BASIS];
   grad_type            cx_ff [NUM_BASIS];   // column copies, rotate every issue
   grad_type            cy_ff [NUM_BASIS];
   grad_type            gx_req [NUM_BASIS];
   grad_type            gy_req [NUM_BASIS];

   // response register
   logic                rsp_valid_ff;
   acc_type             value_ff;
   logic [BASIS_W-1:0]  row_ff, col_ff;
   logic                last_entry_ff;

   logic                req_fire;
   logic                issuing;
   logic                row_step;
   logic                rsp_load;
   tag_type             issue;
   tag_type             term_tag;
   term_type            term_value;
   acc_type             head;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign gx_req[0] = req.grad_x_0;
   assign gx_req[1] = req.grad_x_1;
   assign gx_req[2] = req.grad_x_2;
   assign gx_req[3] = req.grad_x_3;
   assign gy_req[0] = req.grad_y_0;
   assign gy_req[1] = req.grad_y_1;
   assign gy_req[2] = req.grad_y_2;
   assign gy_req[3] = req.grad_y_3;

   assign issuing  = (state_ff == ST_ISSUE);
   assign row_step = issuing && (k_ff[BASIS_W-1:0] == BASIS_W'(NUM_BASIS - 1));
   assign issue    = '{valid: issuing, last: (k_ff == ENTRY_W'(NUM_ENTRIES - 1))};

   // output register takes the next entry when empty or being drained
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   // --- sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_ISSUE;
            k_in     = '0;
         end
         ST_ISSUE: begin
            k_in = k_ff + ENTRY_W'(1);
            if (k_ff == ENTRY_W'(NUM_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // final term lands in the ring this cycle
            if (term_tag.valid && term_tag.last) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
               e_in     = '0;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               e_in = e_ff + ENTRY_W'(1);
               if (e_ff == ENTRY_W'(NUM_ENTRIES - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         e_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         e_ff     <= e_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // --- request capture and operand rotation
   always_ff @(posedge clock) begin
      if (req_fire) begin
         w_ff    <= req.point_weight;
         // |det|; the most negative code maps to 32768 with no wrap
         adet_ff <= req.jacobian_det[GRAD_W-1] ?
                    WGT_W'(~req.jacobian_det + 16'sd1) : WGT_W'(req.jacobian_det);
         last_ff <= req.last_point;
         for (int n = 0; n < NUM_BASIS; n++) begin
            rx_ff[n] <= gx_req[n];
            ry_ff[n] <= gy_req[n];
            cx_ff[n] <= gx_req[n];
            cy_ff[n] <= gy_req[n];
         end
      end else begin
         if (issuing) begin
            for (int n = 0; n < NUM_BASIS; n++) begin
               cx_ff[n] <= cx_ff[(n + 1) % NUM_BASIS];
               cy_ff[n] <= cy_ff[(n + 1) % NUM_BASIS];
            end
         end
         if (row_step) begin
            for (int n = 0; n < NUM_BASIS; n++) begin
               rx_ff[n] <= rx_ff[(n + 1) % NUM_BASIS];
               ry_ff[n] <= ry_ff[(n + 1) % NUM_BASIS];
            end
         end
      end
      if (state_ff == ST_PREP) begin
         scale_ff <= w_ff * adet_ff;
      end
   end

   // --- response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         value_ff      <= head;
         row_ff        <= e_ff[ENTRY_W-1 -: BASIS_W];
         col_ff        <= e_ff[BASIS_W-1:0];
         last_entry_ff <= (e_ff == ENTRY_W'(NUM_ENTRIES - 1));
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.entry_value = value_ff;
   assign rsp.row_index   = row_ff;
   assign rsp.col_index   = col_ff;
   assign rsp.last_entry  = last_entry_ff;

   // --- datapath
   q1es_term_unit u_term (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .gx_i       (rx_ff[0]),
      .gx_j       (cx_ff[0]),
      .gy_i       (ry_ff[0]),
      .gy_j       (cy_ff[0]),
      .scale      (scale_ff),
      .term_tag   (term_tag),
      .term_value (term_value)
   );

   q1es_acc_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .update (term_tag.valid),
      .term   (term_value),
      .pop    (rsp_load),
      .head   (head)
   );

endmodule

// ===== sv/q1es_term_unit.sv =====
// ----------------------------------------------------------------------------
// q1es_term_unit: shared pipelined term datapath
// Four stages: gradient products, sum and magnitude, scale multiply, rounding.
// ----------------------------------------------------------------------------
module q1es_term_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  q1es_pkg::tag_type          issue,
   input  q1es_pkg::grad_type         gx_i,
   input  q1es_pkg::grad_type         gx_j,
   input  q1es_pkg::grad_type         gy_i,
   input  q1es_pkg::grad_type         gy_j,
   input  logic [q1es_pkg::SCALE_W-1:0] scale,
   output q1es_pkg::tag_type          term_tag,
   output q1es_pkg::term_type         term_value
);
   import q1es_pkg::*;

   tag_type                   tag_a_ff, tag_b_ff, tag_c_ff, tag_d_ff;
   logic signed [PAIR_W-1:0]  px_ff, py_ff;
   logic [ABS_W-1:0]          abs_ff, abs_in;
   logic                      pos_b_ff, pos_c_ff, pos_in;
   logic [PROD_W-1:0]         prod_ff;
   term_type                  term_ff, term_in;

   logic signed [PAIR_W:0]    sum;
   logic [PROD_W-1:0]         rnd;
   logic [MAG_W-1:0]          mag;

   // stage B: exact sum, sign and magnitude
   always_comb begin
      sum    = {px_ff[PAIR_W-1], px_ff} + {py_ff[PAIR_W-1], py_ff};
      pos_in = !sum[PAIR_W] && (sum != '0);
      abs_in = sum[PAIR_W] ? ABS_W'(-sum) : sum[ABS_W-1:0];
   end

   // stage D: round half away from zero, apply sign
   always_comb begin
      rnd     = prod_ff + (PROD_W'(1) << (RND_SH - 1));
      mag     = rnd[RND_SH +: MAG_W];
      term_in = pos_c_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
         tag_d_ff <= '0;
      end else begin
         tag_a_ff <= issue;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
         tag_d_ff <= tag_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= gx_i * gx_j;
      py_ff    <= gy_i * gy_j;
      abs_ff   <= abs_in;
      pos_b_ff <= pos_in;
      prod_ff  <= abs_ff * scale;
      pos_c_ff <= pos_b_ff;
      term_ff  <= term_in;
   end

   assign term_tag   = tag_d_ff;
   assign term_value = term_ff;

endmodule

// ===== sv/q1es_acc_ring.sv =====
// ----------------------------------------------------------------------------
// q1es_acc_ring: circulating bank of saturating entry accumulators
// Entries rotate past a single head; updates and read-out both take the head.
// ----------------------------------------------------------------------------
module q1es_acc_ring (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  q1es_pkg::term_type  term,
   input  logic                pop,
   output q1es_pkg::acc_type   head
);
   import q1es_pkg::*;

   acc_type acc_ff [NUM_ENTRIES];
   acc_type tail_in;

   always_comb begin
      tail_in = pop ? '0 : sat_add(acc_ff[0], term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_ENTRIES; n++) begin
            acc_ff[n] <= '0;
         end
      end else if (update || pop) begin
         for (int n = 0; n < NUM_ENTRIES - 1; n++) begin
            acc_ff[n] <= acc_ff[n+1];
         end
         acc_ff[NUM_ENTRIES-1] <= tail_in;
      end
   end

   assign head = acc_ff[0];

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for q1_element_stiffness_top
// Streams quadrature points into the block and checks every emitted stiffness
// entry against a bit-accurate predictor of the 4x4 accumulation. A table of
// hand-picked points comes first, then elements built from random points.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import q1es_pkg::*;

   localparam logic [15:0] G_MIN = 16'h8000;
   localparam logic [15:0] G_MAX = 16'h7FFF;
   localparam logic [15:0] G_ZERO = 16'h0000;
   localparam longint ACC_HI = longint'(ACC_MAX);
   localparam longint ACC_LO = longint'(ACC_MIN);
   localparam int unsigned LONG_POINTS = 8;     // full-scale points per long element
   localparam int unsigned RANDOM_POINTS = 330;

   // how the matrix closed by a last point is checked
   typedef enum logic [1:0] {
      CHECK_PREDICTED,
      CHECK_ALL_ZERO
   } matrix_check_type;

   typedef enum logic [1:0] {
      STYLE_TYPICAL,
      STYLE_FULL,
      STYLE_EXTREME
   } value_style_type;

   typedef struct packed {
      logic [15:0]      weight;
      logic [15:0]      det;
      logic [3:0][15:0] gx;
      logic [3:0][15:0] gy;
      logic             last;
   } quad_point_type;

   typedef struct {
      quad_point_type   pt;
      int unsigned      reps;   // point repeated; last only on the final copy
      matrix_check_type check;
   } stim_row_type;

   typedef struct packed {
      logic [39:0] value;
      logic [1:0]  row;
      logic [1:0]  col;
      logic        last;
   } matrix_entry_type;

   logic clock;
   logic reset;

   q1es_req_if req_bus ();
   q1es_rsp_if rsp_bus ();

   q1_element_stiffness_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   longint           stiffness_acc [NUM_ENTRIES];
   matrix_entry_type pending_entries [$];
   stim_row_type     directed_rows [$];
   int unsigned      mismatch_count = 0;
   bit               sender_calm = 1'b0;
   bit               rsp_calm = 1'b0;
   int unsigned      rsp_hold = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #40_000_000;
      $display("tb: errors");
      $finish;
   end

   task automatic log_mismatch(string msg);
      if (mismatch_count < 50) begin
         $display("tb: mismatch: %s", msg);
      end
      mismatch_count++;
   endtask

   // Mostly back-to-back, some short gaps, the odd long one.
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 50);
   endfunction

   // Predictor: fold one point into the 16 accumulators; a last point queues
   // the whole matrix in row-major order and clears the accumulators.
   function automatic void fold_point(quad_point_type p, matrix_check_type check);
      longint           gx_v [NUM_BASIS];
      longint           gy_v [NUM_BASIS];
      longint           det_v, dot, term, sum;
      longint unsigned  adet, dot_mag, prod, mag;
      matrix_entry_type e;
      int               k;
      det_v = $signed(p.det);
      adet  = (det_v < 0) ? -det_v : det_v;   // -8.0 stays 8.0, no wrap
      for (int i = 0; i < NUM_BASIS; i++) begin
         gx_v[i] = $signed(p.gx[i]);
         gy_v[i] = $signed(p.gy[i]);
      end
      for (int i = 0; i < NUM_BASIS; i++) begin
         for (int j = 0; j < NUM_BASIS; j++) begin
            k       = i * NUM_BASIS + j;
            dot     = gx_v[i] * gx_v[j] + gy_v[i] * gy_v[j];
            dot_mag = (dot < 0) ? -dot : dot;
            prod    = dot_mag * 64'(p.weight) * adet;
            // 50 -> 16 fraction bits, magnitude rounded half away from zero
            mag     = (prod + (64'd1 << 33)) >> 34;
            term    = (dot > 0) ? -longint'(mag) : longint'(mag);
            sum     = stiffness_acc[k] + term;
            if (sum > ACC_HI) sum = ACC_HI;
            if (sum < ACC_LO) sum = ACC_LO;
            stiffness_acc[k] = sum;
         end
      end
      if (p.last) begin
         for (int i = 0; i < NUM_BASIS; i++) begin
            for (int j = 0; j < NUM_BASIS; j++) begin
               k = i * NUM_BASIS + j;
               case (check)
                  CHECK_ALL_ZERO: e.value = '0;
                  default: e.value = stiffness_acc[k][39:0];
               endcase
               e.row  = i[1:0];
               e.col  = j[1:0];
               e.last = (k == NUM_ENTRIES - 1);
               pending_entries.push_back(e);
               stiffness_acc[k] = 0;
            end
         end
      end
   endfunction

   // Present one point and hold it until the block takes it.
   task automatic drive_point(quad_point_type p, matrix_check_type check);
      int unsigned idle;
      idle = sender_calm ? 0 : idle_cycles();
      repeat (idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.point_weight <= p.weight;
      req_bus.jacobian_det <= p.det;
      req_bus.grad_x_0     <= p.gx[0];
      req_bus.grad_x_1     <= p.gx[1];
      req_bus.grad_x_2     <= p.gx[2];
      req_bus.grad_x_3     <= p.gx[3];
      req_bus.grad_y_0     <= p.gy[0];
      req_bus.grad_y_1     <= p.gy[1];
      req_bus.grad_y_2     <= p.gy[2];
      req_bus.grad_y_3     <= p.gy[3];
      req_bus.last_point   <= p.last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      fold_point(p, check);
   endtask

   function automatic void add_row(logic [15:0] weight, logic [15:0] det,
                                   logic [3:0][15:0] gx, logic [3:0][15:0] gy,
                                   logic last, int unsigned reps,
                                   matrix_check_type check);
      stim_row_type row;
      row.pt.weight = weight;
      row.pt.det    = det;
      row.pt.gx     = gx;
      row.pt.gy     = gy;
      row.pt.last   = last;
      row.reps      = reps;
      row.check     = check;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [15:0] random_field(value_style_type style);
      logic [15:0] v;
      case (style)
         STYLE_FULL: v = 16'($urandom);
         STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
               0: v = G_MIN;
               1: v = G_MAX;
               2: v = G_ZERO;
               3: v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         default: v = 16'($urandom_range(0, 8192)) - 16'd4096;   // about +-1.0
      endcase
      return v;
   endfunction

   function automatic quad_point_type random_point(logic last);
      quad_point_type  p;
      value_style_type style;
      int unsigned     r;
      r = $urandom_range(0, 99);
      style = (r < 60) ? STYLE_TYPICAL : (r < 85) ? STYLE_FULL : STYLE_EXTREME;
      p.weight = (style == STYLE_TYPICAL) ? 16'($urandom_range(0, 32768))
                                          : random_field(style);
      p.det = random_field(style);
      for (int i = 0; i < NUM_BASIS; i++) begin
         p.gx[i] = random_field(style);
         p.gy[i] = random_field(style);
      end
      p.last = last;
      return p;
   endfunction

   task automatic check_entry();
      matrix_entry_type want;
      if (pending_entries.size() == 0) begin
         log_mismatch($sformatf("entry (%0d,%0d) = %0d with nothing outstanding",
                                rsp_bus.row_index, rsp_bus.col_index,
                                rsp_bus.entry_value));
         return;
      end
      want = pending_entries.pop_front();
      if (rsp_bus.entry_value !== want.value)
         log_mismatch($sformatf("entry (%0d,%0d) value %0d, expected %0d",
                                want.row, want.col, rsp_bus.entry_value,
                                $signed(want.value)));
      if (rsp_bus.row_index !== want.row)
         log_mismatch($sformatf("row index %0d, expected %0d",
                                rsp_bus.row_index, want.row));
      if (rsp_bus.col_index !== want.col)
         log_mismatch($sformatf("col index %0d, expected %0d",
                                rsp_bus.col_index, want.col));
      if (rsp_bus.last_entry !== want.last)
         log_mismatch($sformatf("entry (%0d,%0d) last flag %b, expected %b",
                                want.row, want.col, rsp_bus.last_entry, want.last));
   endtask

   // Response side: check each accepted entry, then pick next cycle's ready.
   // Calm spells keep ready high for a stretch; otherwise stalls of mixed length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            check_entry();
         end
         if ($urandom_range(0, 199) == 0) begin
            rsp_calm <= !rsp_calm;
         end
         if (rsp_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold      <= rsp_hold - 1;
         end else if (rsp_calm || $urandom_range(0, 99) < 75) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            rsp_hold      <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(0, 2);
         end
      end
   end

   initial begin
      quad_point_type p;
      int unsigned    random_sent;
      int unsigned    elem_len;
      int unsigned    r;

      for (int k = 0; k < NUM_ENTRIES; k++) stiffness_acc[k] = 0;
      random_sent = 0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.point_weight <= '0;
      req_bus.jacobian_det <= '0;
      req_bus.grad_x_0     <= '0;
      req_bus.grad_x_1     <= '0;
      req_bus.grad_x_2     <= '0;
      req_bus.grad_x_3     <= '0;
      req_bus.grad_y_0     <= '0;
      req_bus.grad_y_1     <= '0;
      req_bus.grad_y_2     <= '0;
      req_bus.grad_y_3     <= '0;
      req_bus.last_point   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed table -------------------------------------------------
      // straight out of reset, zero weight: matrix must be all zero
      add_row(16'h0000, G_MIN, {G_MAX, G_MIN, G_MAX, G_MIN},
              {G_MIN, G_MAX, G_MIN, G_MAX}, 1'b1, 1, CHECK_ALL_ZERO);
      // full weight and determinant but flat basis functions
      add_row(16'hFFFF, G_MAX, {4{G_ZERO}}, {4{G_ZERO}}, 1'b1, 1, CHECK_ALL_ZERO);
      // degenerate element, det = 0
      add_row(16'hFFFF, G_ZERO, {G_MIN, G_MAX, G_MIN, G_MAX},
              {G_MAX, G_MAX, G_MIN, G_MIN}, 1'b1, 1, CHECK_ALL_ZERO);
      // term lands exactly on a half LSB: rounds away from zero to -1
      add_row(16'h4000, 16'h0008, {{3{G_ZERO}}, 16'h0100}, {4{G_ZERO}},
              1'b1, 1, CHECK_PREDICTED);
      // same magnitude via negative det and the y gradient
      add_row(16'h4000, 16'hFFF8, {4{G_ZERO}}, {{3{G_ZERO}}, 16'h0100},
              1'b1, 1, CHECK_PREDICTED);
      // just under half an LSB: rounds to zero
      add_row(16'h4000, 16'h0007, {{3{G_ZERO}}, 16'h0100}, {4{G_ZERO}},
              1'b1, 1, CHECK_PREDICTED);
      // a plain 2x2 Gauss element, unit square mapped to a quarter area
      add_row(16'h4000, 16'h0400, {16'h0200, 16'hFE00, 16'hFA00, 16'h0600},
              {16'h0600, 16'h0200, 16'hFE00, 16'hFA00}, 1'b0, 1, CHECK_PREDICTED);
      add_row(16'h4000, 16'h0400, {16'h0200, 16'hFE00, 16'hFA00, 16'h0600},
              {16'h0200, 16'h0600, 16'hFA00, 16'hFE00}, 1'b0, 1, CHECK_PREDICTED);
      add_row(16'h4000, 16'h0400, {16'h0600, 16'hFA00, 16'hFE00, 16'h0200},
              {16'h0200, 16'h0600, 16'hFA00, 16'hFE00}, 1'b0, 1, CHECK_PREDICTED);
      add_row(16'h4000, 16'h0400, {16'h0600, 16'hFA00, 16'hFE00, 16'h0200},
              {16'h0600, 16'h0200, 16'hFE00, 16'hFA00}, 1'b1, 1, CHECK_PREDICTED);
      // mixed signs at full scale, most negative det
      add_row(16'hFFFF, G_MIN, {16'hF000, 16'h1000, G_MIN, G_MAX},
              {G_MAX, 16'hFFFF, 16'h0001, G_MIN}, 1'b1, 1, CHECK_PREDICTED);
      // largest positive everything
      add_row(16'hFFFF, G_MAX, {4{G_MAX}}, {4{G_MAX}}, 1'b1, 1, CHECK_PREDICTED);
      // long element at full scale: the largest terms pile up
      add_row(16'hFFFF, G_MIN, {G_MIN, G_MAX, G_MIN, G_MAX},
              {G_MIN, G_MAX, G_MIN, G_MAX}, 1'b1, LONG_POINTS, CHECK_PREDICTED);
      // accumulators must be clear again
      add_row(16'h4000, 16'h1000, {16'h0800, 16'hF800, 16'h0400, 16'hFC00},
              {16'hFC00, 16'h0400, 16'hF800, 16'h0800}, 1'b1, 1, CHECK_PREDICTED);
      // build up large sums, then one large term pulls half of them back and pushes the rest further
      add_row(16'hFFFF, G_MIN, {G_MIN, G_MAX, G_MIN, G_MAX},
              {G_MIN, G_MAX, G_MIN, G_MAX}, 1'b0, LONG_POINTS, CHECK_PREDICTED);
      add_row(16'hFFFF, G_MIN, {4{G_MIN}}, {4{G_MIN}}, 1'b1, 1, CHECK_PREDICTED);

      foreach (directed_rows[n]) begin
         sender_calm = (n % 3 == 0);
         for (int unsigned k = 0; k < directed_rows[n].reps; k++) begin
            p      = directed_rows[n].pt;
            p.last = directed_rows[n].pt.last && (k == directed_rows[n].reps - 1);
            drive_point(p, directed_rows[n].check);
         end
      end

      // --- random elements ------------------------------------------------
      // Mostly four-point Gauss elements; some one-point, odd lengths, and a
      // few long ones that push the accumulators hard.
      while (random_sent < RANDOM_POINTS) begin
         r = $urandom_range(0, 99);
         if (r < 70)      elem_len = 4;
         else if (r < 80) elem_len = 1;
         else if (r < 95) elem_len = $urandom_range(2, 9);
         else             elem_len = $urandom_range(10, 40);
         sender_calm = ($urandom_range(0, 4) == 0);
         for (int unsigned k = 0; k < elem_len; k++) begin
            drive_point(random_point(k == elem_len - 1), CHECK_PREDICTED);
            random_sent++;
         end
      end
      req_bus.valid <= 1'b0;

      // drain outstanding entries, then give stray responses time to show
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
